// ===== hw/rtl/spr_pkg.sv =====
// Shared types, constants and helper functions for the stream pattern replace block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package spr_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 64;
    localparam int LEN_W     = 4;
    localparam int CNT_W     = 4;
    localparam int IDX_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int WIN_DEPTH = 8;

    localparam int PATTERN_MAX_DEF     = 8;
    localparam int REPLACEMENT_MAX_DEF = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES     = 2'd0,
        REG_PATTERN_LENGTH    = 2'd1,
        REG_REPLACEMENT_BYTES = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_FLUSH = 2'd1,
        MODE_REPL  = 2'd2
    } mode_t;

    // Control handed from the sequencer to the window chain each cycle.
    typedef struct packed {
        logic             sel_valid;
        logic             load;
        logic             shift;
        logic [CNT_W-1:0] count;
    } win_ctrl_t;

    // Length in use: capped, then cut at the first zero byte of the register.
    function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] bytes,
                                                 input logic [LEN_W-1:0] len,
                                                 input logic [LEN_W-1:0] cap);
        logic [LEN_W-1:0] n;
        logic [LEN_W-1:0] res;
        n   = (len > cap) ? cap : len;
        res = n;
        for (int i = WIN_DEPTH - 1; i >= 0; i--)
        begin
            if ((LEN_W'(i) < n) && (bytes[i*BYTE_W +: BYTE_W] == '0))
            begin
                res = LEN_W'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/spr_in_if.sv =====
// Input byte stream channel: valid/ready handshake with one character per transaction.
// Depends on spr_pkg for the byte width.
`default_nettype none

interface spr_in_if import spr_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              byte_present;
    logic              end_of_string;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_string, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input end_of_string, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/spr_out_if.sv =====
// Result byte stream channel: valid/ready handshake with one character per transaction.
// Depends on spr_pkg for the byte width.
`default_nettype none

interface spr_out_if import spr_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_present;
    logic              out_last;

    modport source (output valid, output out_byte, output out_present,
                    output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_present,
                    input out_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/spr_cfg_if.sv =====
// Configuration write channel: register index and write data under valid/ready.
// Depends on spr_pkg for the index and data widths.
`default_nettype none

interface spr_cfg_if import spr_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/spr_cell.sv =====
// One window cell: holds a pending byte, compares it to its pattern byte, shifts left.
// Depends on spr_pkg.
`default_nettype none

module spr_cell import spr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic              sel,
    input  wire logic              load,
    input  wire logic              shift,
    input  wire logic [BYTE_W-1:0] right_view,
    input  wire logic [BYTE_W-1:0] pattern_byte,
    output      logic [BYTE_W-1:0] view,
    output      logic              eq
);

    logic [BYTE_W-1:0] held_reg;

    // The view already contains the byte arriving this cycle when it lands here.
    assign view = sel ? data_byte : held_reg;
    assign eq   = (view == pattern_byte);

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            held_reg <= right_view;
        end
        else if (load && sel)
        begin
            held_reg <= data_byte;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/spr_window.sv =====
// Row of window cells holding the pending bytes, with the whole-window match reduction.
// Depends on spr_pkg and spr_cell.
`default_nettype none

module spr_window import spr_pkg::*;
#(
    parameter int CELLS = WIN_DEPTH
)
(
    input  wire logic              clk,
    input  wire win_ctrl_t         ctrl,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic [CFG_W-1:0]  pattern_bytes,
    input  wire logic [LEN_W-1:0]  plen,
    output      logic [BYTE_W-1:0] head,
    output      logic              match
);

    logic [BYTE_W-1:0] view [CELLS];
    logic [CELLS-1:0]  eq;
    logic [CELLS-1:0]  in_use;

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        logic [BYTE_W-1:0] right;
        logic              sel;

        if (i == CELLS - 1)
        begin : g_end
            assign right = view[i];
        end
        else
        begin : g_mid
            assign right = view[i+1];
        end

        assign sel       = ctrl.sel_valid && (ctrl.count == CNT_W'(i));
        assign in_use[i] = (LEN_W'(i) < plen);

        spr_cell u_cell (
            .clk          (clk),
            .data_byte    (data_byte),
            .sel          (sel),
            .load         (ctrl.load),
            .shift        (ctrl.shift),
            .right_view   (right),
            .pattern_byte (pattern_bytes[i*BYTE_W +: BYTE_W]),
            .view         (view[i]),
            .eq           (eq[i])
        );
    end

    assign head  = view[0];
    assign match = &(eq | ~in_use);

endmodule

`default_nettype wire

// ===== hw/rtl/stream_pattern_replace_top.sv =====
// Top level of the streaming find-and-replace block: config registers, sequencer,
// window cell chain and output register. Depends on spr_pkg, the spr_*_if interfaces
// and spr_window.
//
// Usage: characters enter one per transaction on byte_stream (data_byte, byte_present,
// end_of_string). Rewritten characters leave on result_stream with out_present and
// out_last; out_last marks the final transaction of each rewritten string. A string that
// rewrites to nothing yields one bare marker transaction (out_present low, out_last high).
// The cfg channel writes the four registers by index; it is always ready and must only be
// used while no string is in flight. Writing the pattern or its length discards the
// pending window. Throughput is one input transaction per cycle. A match emits its
// replacement bytes one after another, and the end of a string its pending bytes; the
// input is held off while such a burst is still being emitted. A result appears on
// result_stream in the cycle after the transaction that causes it (output register).
// When the receiver stalls, the output register holds and the input is held off too.
// Reset clears the registers to zero (pass-through), the pending count and the output valid flag.
// The pending bytes themselves live in a chain of cells that shifts toward the head.
`default_nettype none

module stream_pattern_replace_top import spr_pkg::*;
#(
    parameter int PATTERN_MAX     = PATTERN_MAX_DEF,
    parameter int REPLACEMENT_MAX = REPLACEMENT_MAX_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    spr_in_if.sink    byte_stream,
    spr_out_if.source result_stream,
    spr_cfg_if.sink   cfg
);

    // The window never holds more than eight bytes, whatever the parameter says.
    localparam int CELLS = (PATTERN_MAX < WIN_DEPTH) ? PATTERN_MAX : WIN_DEPTH;
    localparam int RCAP  = (REPLACEMENT_MAX < WIN_DEPTH) ? REPLACEMENT_MAX : WIN_DEPTH;

    // Configuration registers.
    logic [CFG_W-1:0] pat_bytes_reg;
    logic [LEN_W-1:0] pat_len_reg;
    logic [CFG_W-1:0] rep_bytes_reg;
    logic [LEN_W-1:0] rep_len_reg;

    // Sequencer state.
    mode_t            mode_reg, mode_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             eos_reg, eos_next;

    // Output register.
    logic              ov_reg;
    logic [BYTE_W-1:0] ob_reg;
    logic              op_reg;
    logic              ol_reg;

    logic [LEN_W-1:0]  plen;
    logic [LEN_W-1:0]  rlen;
    logic              adv;
    logic              idle;
    logic              acc;
    logic              cfg_acc;
    logic              din_valid;
    logic              eos;
    logic [CNT_W-1:0]  cnt1;
    logic              full;
    logic              hit;
    logic              repl_end;
    logic [BYTE_W-1:0] head;
    logic              win_match;
    logic [BYTE_W-1:0] rep_byte;
    win_ctrl_t         ctrl;

    logic              emit;
    logic [BYTE_W-1:0] e_byte;
    logic              e_present;
    logic              e_last;

    assign plen = eff_len(pat_bytes_reg, pat_len_reg, LEN_W'(CELLS));
    assign rlen = eff_len(rep_bytes_reg, rep_len_reg, LEN_W'(RCAP));

    // The output register can take a new transaction when empty or being drained.
    assign adv       = !ov_reg || result_stream.ready;
    assign idle      = (mode_reg == MODE_IDLE);
    assign acc       = byte_stream.valid && byte_stream.ready;
    assign cfg_acc   = cfg.valid && cfg.ready;
    assign din_valid = byte_stream.byte_present && (byte_stream.data_byte != '0);
    assign eos       = byte_stream.end_of_string;
    assign cnt1      = count_reg + CNT_W'(din_valid);
    assign full      = (plen != '0) && (cnt1 == plen);
    assign hit       = full && win_match;
    assign repl_end  = ({1'b0, idx_reg} == (rlen - LEN_W'(1)));
    assign rep_byte  = rep_bytes_reg[idx_reg*BYTE_W +: BYTE_W];

    assign byte_stream.ready = idle && adv;
    assign cfg.ready         = 1'b1;

    assign result_stream.valid       = ov_reg;
    assign result_stream.out_byte    = ob_reg;
    assign result_stream.out_present = op_reg;
    assign result_stream.out_last    = ol_reg;

    spr_window #(
        .CELLS (CELLS)
    ) u_window (
        .clk           (clk),
        .ctrl          (ctrl),
        .data_byte     (byte_stream.data_byte),
        .pattern_bytes (pat_bytes_reg),
        .plen          (plen),
        .head          (head),
        .match         (win_match)
    );

    // Next mode of the sequencer: bursts of replacement bytes or of leftover bytes.
    always_comb
    begin
        mode_next = mode_reg;
        unique case (mode_reg)
            MODE_IDLE:
            begin
                if (acc && (plen != '0))
                begin
                    if (hit)
                    begin
                        if (rlen > LEN_W'(1))
                        begin
                            mode_next = MODE_REPL;
                        end
                    end
                    else if ((full || eos) && eos && (cnt1 > CNT_W'(1)))
                    begin
                        mode_next = MODE_FLUSH;
                    end
                end
            end
            MODE_FLUSH:
            begin
                if (adv && (count_reg == CNT_W'(1)))
                begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_REPL:
            begin
                if (adv && repl_end)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    // Result generation, window control and counters.
    always_comb
    begin
        emit       = 1'b0;
        e_byte     = '0;
        e_present  = 1'b0;
        e_last     = 1'b0;
        count_next = count_reg;
        idx_next   = idx_reg;
        eos_next   = eos_reg;
        ctrl.sel_valid = idle && din_valid && (plen != '0);
        ctrl.load      = 1'b0;
        ctrl.shift     = 1'b0;
        ctrl.count     = count_reg;
        unique case (mode_reg)
            MODE_IDLE:
            begin
                if (acc)
                begin
                    if (plen == '0)
                    begin
                        // Pass through: every nonzero character goes straight out.
                        if (din_valid || eos)
                        begin
                            emit      = 1'b1;
                            e_byte    = din_valid ? byte_stream.data_byte : '0;
                            e_present = din_valid;
                            e_last    = eos;
                        end
                        count_next = '0;
                    end
                    else
                    begin
                        ctrl.load = 1'b1;
                        if (hit)
                        begin
                            count_next = '0;
                            idx_next   = IDX_W'(1);
                            eos_next   = eos;
                            if (rlen != '0)
                            begin
                                emit      = 1'b1;
                                e_byte    = rep_bytes_reg[BYTE_W-1:0];
                                e_present = 1'b1;
                                e_last    = eos && (rlen == LEN_W'(1));
                            end
                            else if (eos)
                            begin
                                // Deleted match at the end of a string: a bare end marker closes it.
                                emit   = 1'b1;
                                e_last = 1'b1;
                            end
                        end
                        else if (full || (eos && (cnt1 != '0)))
                        begin
                            // The oldest byte leaves and the chain moves up one cell.
                            emit       = 1'b1;
                            e_byte     = head;
                            e_present  = 1'b1;
                            e_last     = eos && (cnt1 == CNT_W'(1));
                            ctrl.shift = 1'b1;
                            count_next = cnt1 - CNT_W'(1);
                        end
                        else
                        begin
                            count_next = cnt1;
                            if (eos)
                            begin
                                emit   = 1'b1;
                                e_last = 1'b1;
                            end
                        end
                    end
                end
            end
            MODE_FLUSH:
            begin
                if (adv)
                begin
                    emit       = 1'b1;
                    e_byte     = head;
                    e_present  = 1'b1;
                    e_last     = (count_reg == CNT_W'(1));
                    ctrl.shift = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            MODE_REPL:
            begin
                if (adv)
                begin
                    emit      = 1'b1;
                    e_byte    = rep_byte;
                    e_present = 1'b1;
                    e_last    = eos_reg && repl_end;
                    idx_next  = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        // A new pattern or pattern length throws the pending window away.
        if (cfg_acc && (cfg_reg_t'(cfg.index) inside {REG_PATTERN_BYTES, REG_PATTERN_LENGTH}))
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= '0;
            rep_bytes_reg <= '0;
            rep_len_reg   <= '0;
            mode_reg      <= MODE_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            eos_reg       <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            eos_reg   <= eos_next;
            if (adv)
            begin
                ov_reg <= emit;
            end
            if (cfg_acc)
            begin
                unique case (cfg_reg_t'(cfg.index))
                    REG_PATTERN_BYTES:
                    begin
                        pat_bytes_reg <= cfg.data;
                    end
                    REG_PATTERN_LENGTH:
                    begin
                        pat_len_reg <= cfg.data[LEN_W-1:0];
                    end
                    REG_REPLACEMENT_BYTES:
                    begin
                        rep_bytes_reg <= cfg.data;
                    end
                    REG_REPLACEMENT_LENGTH:
                    begin
                        rep_len_reg <= cfg.data[LEN_W-1:0];
                    end
                    default:
                    begin
                        rep_len_reg <= rep_len_reg;
                    end
                endcase
            end
        end
    end

    // Output payload needs no reset; it is qualified by ov_reg.
    always_ff @(posedge clk)
    begin
        if (adv && emit)
        begin
            ob_reg <= e_byte;
            op_reg <= e_present;
            ol_reg <= e_last;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/spr_checker.sv =====
// Port-level assertions for the stream pattern replace block, bound to its top level.
// Depends on stream_pattern_replace_top and the spr_*_if interfaces.
`default_nettype none

module spr_checker import spr_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [BYTE_W-1:0] out_byte,
    input wire logic              out_present,
    input wire logic              out_last
);

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(out_present) && $stable(out_last))
        else $error("result transaction changed while stalled");

    // A bare marker only closes a string and carries a zero byte.
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_present |-> out_last && (out_byte == '0))
        else $error("bare marker without out_last or with a byte");

    // Zero bytes are dropped and cut the registers, so no character is zero.
    a_no_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_present |-> (out_byte != '0))
        else $error("zero character on the result stream");

    // A stalled receiver holds off the input side as well.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while the result stream is stalled");

endmodule

bind stream_pattern_replace_top spr_checker u_spr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (byte_stream.ready),
    .out_valid   (result_stream.valid),
    .out_ready   (result_stream.ready),
    .out_byte    (result_stream.out_byte),
    .out_present (result_stream.out_present),
    .out_last    (result_stream.out_last)
);

`default_nettype wire

// ===== tb/sv/stream_pattern_replace_top_tb.sv =====
// Self-checking testbench for stream_pattern_replace_top: directed and random strings
// through the find-and-replace block. Depends on spr_pkg, the spr_*_if interfaces and the RTL.
module stream_pattern_replace_top_tb;
    import spr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAT_CAP     = (PATTERN_MAX_DEF < WIN_DEPTH) ? PATTERN_MAX_DEF : WIN_DEPTH;
    localparam int REP_CAP     = (REPLACEMENT_MAX_DEF < WIN_DEPTH) ?
                                 REPLACEMENT_MAX_DEF : WIN_DEPTH;
    localparam int DRAIN_GAP   = 24;    // longest burst is eight results plus slack
    localparam int HOLD_AT     = 150;   // result count at which the long receiver hold starts
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 4000;  // several times the longest legal quiet stretch
    localparam int RANDOM_CHARS = 350;

    // One character transaction on the input side and one on the result side.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              byte_present;
        logic              end_of_string;
    } in_char_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_present;
        logic              out_last;
    } out_char_t;

    logic clk;
    logic rst_n;

    spr_in_if  byte_if ();
    spr_out_if res_if ();
    spr_cfg_if cfg_if ();

    stream_pattern_replace_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_stream   (byte_if),
        .result_stream (res_if),
        .cfg           (cfg_if)
    );

    // Shadow copy of the configuration registers and of the pending window.
    logic [CFG_W-1:0]  pat_bytes;
    logic [LEN_W-1:0]  pat_len;
    logic [CFG_W-1:0]  rep_bytes;
    logic [LEN_W-1:0]  rep_len;
    logic [BYTE_W-1:0] win_bytes [WIN_DEPTH];
    int                win_count;

    in_char_t  staged [$];       // characters being assembled before they are handed over
    in_char_t  string_q [$];     // characters waiting for the input driver
    out_char_t rewritten_q [$];  // rewritten characters the block still owes us
    int        chars_in_flight;  // handed to the driver but not yet accepted
    int        useful_chars;     // characters that are neither dropped nor ignored

    int        burst_left;
    int        gap_left;
    in_char_t  next_char;

    int        results_seen;
    int        hold_left;
    bit        hold_done;
    logic [15:0] stall_tick;
    logic      next_ready;
    out_char_t want;
    out_char_t got;

    int        mismatches;
    int        quiet_cycles;

    // Number of register bytes in use: saturate at the cap, then stop at the first zero byte.
    function automatic int used_len(logic [CFG_W-1:0] bytes, logic [LEN_W-1:0] len, int cap);
        int n;
        n = (int'(len) > cap) ? cap : int'(len);
        for (int i = 0; i < n; i++)
        begin
            if (bytes[i*BYTE_W +: BYTE_W] == '0)
            begin
                return i;
            end
        end
        return n;
    endfunction

    function automatic out_char_t lit_char(logic [BYTE_W-1:0] b, logic present);
        out_char_t c;
        c.out_byte    = b;
        c.out_present = present;
        c.out_last    = 1'b0;
        return c;
    endfunction

    // Advances the shadow window by one accepted character and queues what the block
    // must produce for it. The whole burst is built first so that the end mark can be set
    // on its final character.
    function automatic void rewrite_step(logic [BYTE_W-1:0] ch, logic present, logic eos);
        out_char_t burst [$];
        int        plen;
        int        rlen;
        logic      take;
        logic      hit;
        take = present && (ch != '0);
        plen = used_len(pat_bytes, pat_len, PAT_CAP);
        rlen = used_len(rep_bytes, rep_len, REP_CAP);
        if (plen == 0)
        begin
            if (take)
            begin
                burst.push_back(lit_char(ch, 1'b1));
            end
        end
        else
        begin
            if (take && win_count < plen)
            begin
                win_bytes[win_count] = ch;
                win_count++;
            end
            if (win_count >= plen)
            begin
                hit = 1'b1;
                for (int i = 0; i < plen; i++)
                begin
                    if (win_bytes[i] != pat_bytes[i*BYTE_W +: BYTE_W])
                    begin
                        hit = 1'b0;
                    end
                end
                if (hit)
                begin
                    for (int i = 0; i < rlen; i++)
                    begin
                        burst.push_back(lit_char(rep_bytes[i*BYTE_W +: BYTE_W], 1'b1));
                    end
                    win_count = 0;
                end
                else
                begin
                    // No match: the oldest byte can no longer start one, so it leaves.
                    burst.push_back(lit_char(win_bytes[0], 1'b1));
                    for (int i = 1; i < WIN_DEPTH; i++)
                    begin
                        win_bytes[i-1] = win_bytes[i];
                    end
                    win_count--;
                end
            end
            if (eos)
            begin
                for (int i = 0; i < win_count; i++)
                begin
                    burst.push_back(lit_char(win_bytes[i], 1'b1));
                end
            end
        end
        if (eos)
        begin
            // A string that rewrites to nothing still closes with a bare end marker.
            if (burst.size() == 0)
            begin
                burst.push_back(lit_char('0, 1'b0));
            end
            burst[burst.size()-1].out_last = 1'b1;
            win_count = 0;
        end
        foreach (burst[i])
        begin
            rewritten_q.push_back(burst[i]);
        end
    endfunction

    task automatic note_mismatch(string what, out_char_t exp_c, out_char_t act_c);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s: expected %02h/%0b/%0b, got %02h/%0b/%0b (byte/present/last)",
                     $realtime, what, exp_c.out_byte, exp_c.out_present, exp_c.out_last,
                     act_c.out_byte, act_c.out_present, act_c.out_last);
        end
    endtask

    // Register writes go out only while the block is idle; the shadow follows on the
    // edge that completes the transaction.
    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready)
        begin
            @(posedge clk);
        end
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_PATTERN_BYTES:
            begin
                pat_bytes = val;
                win_count = 0;
            end
            REG_PATTERN_LENGTH:
            begin
                pat_len   = val[LEN_W-1:0];
                win_count = 0;
            end
            REG_REPLACEMENT_BYTES:  rep_bytes = val;
            REG_REPLACEMENT_LENGTH: rep_len   = val[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic stage_char(logic [BYTE_W-1:0] d, logic present, logic eos);
        in_char_t c;
        c.data_byte     = d;
        c.byte_present  = present;
        c.end_of_string = eos;
        staged.push_back(c);
    endtask

    // Hands the staged characters to the driver away from the active clock edge.
    task automatic send_staged();
        @(negedge clk);
        foreach (staged[i])
        begin
            string_q.push_back(staged[i]);
            if ((staged[i].byte_present && staged[i].data_byte != '0) ||
                staged[i].end_of_string)
            begin
                useful_chars++;
            end
        end
        chars_in_flight += staged.size();
        staged.delete();
    endtask

    // Waits until every character was accepted and every rewritten character came back,
    // then lets the block settle before anything else happens.
    task automatic wait_idle();
        do
        begin
            @(posedge clk);
        end
        while (chars_in_flight != 0 || rewritten_q.size() != 0);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    // One random string, mostly built from copies and fragments of the pattern so that
    // matches, near misses and flushes are common, with some noise mixed in.
    task automatic stage_string();
        int plen;
        int pieces;
        int kind;
        int cut;
        int first;
        plen   = used_len(pat_bytes, pat_len, PAT_CAP);
        first  = staged.size();
        pieces = $urandom_range(0, 8);
        for (int p = 0; p < pieces; p++)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 3 && plen > 0)
            begin
                for (int i = 0; i < plen; i++)
                begin
                    stage_char(pat_bytes[i*BYTE_W +: BYTE_W], 1'b1, 1'b0);
                end
            end
            else if (kind <= 5 && plen > 1)
            begin
                cut = $urandom_range(1, plen - 1);
                for (int i = 0; i < cut; i++)
                begin
                    stage_char(pat_bytes[i*BYTE_W +: BYTE_W], 1'b1, 1'b0);
                end
            end
            else if (kind == 6)
            begin
                stage_char(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b0);
            end
            else if (kind == 7)
            begin
                // Noise: a zero character or a transaction without a character.
                if ($urandom_range(0, 1) == 0)
                begin
                    stage_char('0, 1'b1, 1'b0);
                end
                else
                begin
                    stage_char(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0);
                end
            end
            else
            begin
                stage_char(BYTE_W'(8'h61 + $urandom_range(0, 2)), 1'b1, 1'b0);
            end
        end
        if (staged.size() == first || $urandom_range(0, 3) == 0)
        begin
            stage_char(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
        else
        begin
            staged[staged.size()-1].end_of_string = 1'b1;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Input driver: pops pending characters and offers them in bursts of random length
    // separated by random gaps. Prediction happens on the accepting edge, so the shadow
    // state always follows the order in which the block really took the characters.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_if.valid && byte_if.ready)
            begin
                rewrite_step(byte_if.data_byte, byte_if.byte_present, byte_if.end_of_string);
                chars_in_flight--;
            end
            if (!byte_if.valid || byte_if.ready)
            begin
                if (gap_left == 0 && string_q.size() != 0)
                begin
                    next_char = string_q.pop_front();
                    byte_if.valid         <= 1'b1;
                    byte_if.data_byte     <= next_char.data_byte;
                    byte_if.byte_present  <= next_char.byte_present;
                    byte_if.end_of_string <= next_char.end_of_string;
                    if (burst_left <= 1)
                    begin
                        // About a third of the bursts run straight into the next one.
                        burst_left = $urandom_range(1, 32);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    byte_if.valid <= 1'b0;
                    if (gap_left != 0)
                    begin
                        gap_left--;
                    end
                end
            end
        end
    end

    // Result monitor: checks every accepted result against the oldest expectation and
    // drives ready. Bits 9:8 of stall_tick choose the stall pattern: always ready,
    // light random stalls, heavy random stalls or a fixed periodic stall. Once, after
    // HOLD_AT results, ready stays low for HOLD_CYCLES so that the output register and
    // then the input back up while the driver keeps offering characters.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                results_seen++;
                got.out_byte    = res_if.out_byte;
                got.out_present = res_if.out_present;
                got.out_last    = res_if.out_last;
                if (rewritten_q.size() == 0)
                begin
                    note_mismatch("result with nothing expected", '0, got);
                end
                else
                begin
                    want = rewritten_q.pop_front();
                    if (got.out_byte != want.out_byte || got.out_present != want.out_present ||
                        got.out_last != want.out_last)
                    begin
                        note_mismatch("result mismatch", want, got);
                    end
                end
            end
            if (hold_left != 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done  = 1'b1;
                hold_left  = HOLD_CYCLES - 1;
                next_ready = 1'b0;
            end
            else
            begin
                case (stall_tick[9:8])
                    2'd0:    next_ready = 1'b1;
                    2'd1:    next_ready = ($urandom_range(0, 3) != 0);
                    2'd2:    next_ready = ($urandom_range(0, 9) < 3);
                    default: next_ready = (stall_tick[2:0] != 3'd5);
                endcase
            end
            res_if.ready <= next_ready;
            stall_tick++;
        end
    end

    // Watchdog: a run in which no channel moves until quiet_cycles reaches QUIET_LIMIT has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("stream_pattern_replace_top test failed");
            $finish;
        end
    end

    initial
    begin
        int pl;
        int rl;
        int phase;
        int target;
        logic [CFG_W-1:0] pat_val;
        logic [CFG_W-1:0] rep_val;

        // Everything the testbench drives is known from time zero.
        rst_n                 = 1'b0;
        byte_if.valid         = 1'b0;
        byte_if.data_byte     = '0;
        byte_if.byte_present  = 1'b0;
        byte_if.end_of_string = 1'b0;
        res_if.ready          = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = REG_PATTERN_BYTES;
        cfg_if.data           = '0;
        pat_bytes = '0;
        pat_len   = '0;
        rep_bytes = '0;
        rep_len   = '0;
        win_count = 0;
        foreach (win_bytes[i])
        begin
            win_bytes[i] = '0;
        end
        chars_in_flight = 0;
        useful_chars    = 0;
        burst_left      = 0;
        gap_left        = 0;
        results_seen    = 0;
        hold_left       = 0;
        hold_done       = 1'b0;
        stall_tick      = '0;
        mismatches      = 0;
        quiet_cycles    = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Registers come out of reset as pass-through. Lowest and highest characters go
        // straight through, a zero character and a transaction without a character vanish,
        // and an end-only string gives a bare end marker.
        stage_char(8'h01, 1'b1, 1'b0);
        stage_char(8'h00, 1'b1, 1'b0);
        stage_char(8'hFF, 1'b0, 1'b0);
        stage_char(8'hFF, 1'b1, 1'b1);
        stage_char(8'h00, 1'b0, 1'b1);
        send_staged();
        wait_idle();

        // "ab" becomes "XYZ". The replacement length of 5 is cut to 3 at the zero byte.
        // "aab" gives "a" then the replacement; a plain "ab" with the replacement length set
        // to zero deletes the whole string and leaves a bare end marker.
        write_reg(REG_PATTERN_BYTES, 64'h0000_0000_0000_6261);
        write_reg(REG_PATTERN_LENGTH, 64'd2);
        write_reg(REG_REPLACEMENT_BYTES, 64'h0000_0000_005A_5958);
        write_reg(REG_REPLACEMENT_LENGTH, 64'd5);
        stage_char(8'h61, 1'b1, 1'b0);
        stage_char(8'h61, 1'b1, 1'b0);
        stage_char(8'h62, 1'b1, 1'b1);
        send_staged();
        wait_idle();
        write_reg(REG_REPLACEMENT_LENGTH, 64'd0);
        stage_char(8'h61, 1'b1, 1'b0);
        stage_char(8'h62, 1'b1, 1'b1);
        send_staged();
        wait_idle();

        // Full eight-byte pattern with a length of 15 that saturates to 8 and a full
        // replacement: a leading miss, then one match that yields eight results in one burst.
        write_reg(REG_PATTERN_BYTES, 64'h4847_4645_4443_4241);
        write_reg(REG_PATTERN_LENGTH, 64'd15);
        write_reg(REG_REPLACEMENT_BYTES, 64'hFF80_7F01_FE02_AA55);
        write_reg(REG_REPLACEMENT_LENGTH, 64'd8);
        stage_char(8'h5A, 1'b1, 1'b0);
        for (int i = 0; i < 8; i++)
        begin
            stage_char(BYTE_W'(8'h41 + i), 1'b1, (i == 7));
        end
        send_staged();
        wait_idle();

        // Pattern change in the middle of a string: "abc" (cut at its zero byte) holds two
        // pending bytes, then the new pattern "bc" throws them away and matches afresh.
        write_reg(REG_PATTERN_BYTES, 64'h0000_0000_0063_6261);
        stage_char(8'h61, 1'b1, 1'b0);
        stage_char(8'h62, 1'b1, 1'b0);
        send_staged();
        wait_idle();
        write_reg(REG_PATTERN_BYTES, 64'h0000_0000_0000_6362);
        stage_char(8'h62, 1'b1, 1'b0);
        stage_char(8'h63, 1'b1, 1'b1);
        send_staged();
        wait_idle();

        // Random phases: a fresh configuration each time, then a batch of strings. The
        // first phase is pass-through and the second uses the largest sizes.
        target = useful_chars + RANDOM_CHARS;
        phase  = 0;
        while (useful_chars < target)
        begin
            pl = $urandom_range(0, 9);
            if (pl == 9)
            begin
                pl = $urandom_range(9, 15);
            end
            rl = $urandom_range(0, 9);
            if (rl == 9)
            begin
                rl = $urandom_range(9, 15);
            end
            if (phase == 0)
            begin
                pl = 0;
            end
            else if (phase == 1)
            begin
                pl = 8;
                rl = 8;
            end
            for (int i = 0; i < 8; i++)
            begin
                pat_val[i*BYTE_W +: BYTE_W] = ($urandom_range(0, 4) == 0) ?
                    BYTE_W'($urandom_range(1, 255)) : BYTE_W'(8'h61 + $urandom_range(0, 2));
                rep_val[i*BYTE_W +: BYTE_W] = BYTE_W'($urandom_range(1, 255));
            end
            if (phase > 1 && $urandom_range(0, 5) == 0)
            begin
                pat_val[$urandom_range(0, 7)*BYTE_W +: BYTE_W] = '0;
            end
            if (phase > 1 && $urandom_range(0, 5) == 0)
            begin
                rep_val[$urandom_range(0, 7)*BYTE_W +: BYTE_W] = '0;
            end
            write_reg(REG_PATTERN_BYTES, pat_val);
            write_reg(REG_PATTERN_LENGTH, CFG_W'(pl));
            write_reg(REG_REPLACEMENT_BYTES, rep_val);
            write_reg(REG_REPLACEMENT_LENGTH, CFG_W'(rl));
            while (staged.size() < 45)
            begin
                stage_string();
            end
            send_staged();
            wait_idle();
            phase++;
        end

        if (mismatches == 0)
        begin
            $display("stream_pattern_replace_top test passed");
        end
        else
        begin
            $display("stream_pattern_replace_top test failed");
        end
        $finish;
    end

endmodule
